>>> sv/b64d_pkg.sv
// Package for the base64 stream decoder: alphabet constants, register indexes
// and the character-to-sextet lookup. It depends on nothing else.
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;

    localparam int unsigned CFG_WIDTH       = 4;
    localparam int unsigned CFG_INDEX_WIDTH = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SKIP_PREFIX = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DROP_ZERO   = 1'd1;

    localparam logic [3:0] SKIP_PREFIX_RESET = 4'd2;
    localparam logic       DROP_ZERO_RESET   = 1'b1;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == CHAR_PLUS) begin
            s.value = 6'd62;
        end else if (c == CHAR_SLASH) begin
            s.value = 6'd63;
        end else if (c == CHAR_PAD) begin
            s.value = 6'd0;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> sv/base64_stream_decoder_unit.sv
// Top level of the base64 stream decoder: one character in, at most one byte out.
// Depends on b64d_pkg for the alphabet lookup and register indexes.
//
//  Channel   Direction  Fields
//  s_        in         tdata[7:0] char_code, tlast end_of_input
//  m_        out        tdata[7:0] data_byte, tuser byte_valid, tlast string_done
//  cfg_      in         index 0 skip_prefix_bytes, index 1 drop_zero_bytes
//
// One character is taken every cycle unless the output register is full and
// not being read; its result, if any, is written to the output register as it
// is taken. The accumulator update is a single pass of logic in between.
// A stalled output register holds the input only while it is full.
// Reset is synchronous; it clears the state and the output valid flag and sets
// the configuration to its defaults. The output data, tuser and tlast are not reset.
`default_nettype none

module base64_stream_decoder_unit
    import b64d_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] char_code
    input  wire logic                       s_tlast,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] data_byte
    output logic                            m_tuser,   // [0] byte_valid
    output logic                            m_tlast,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]       cfg_wdata
);

    logic [3:0]  skip_prefix_reg;
    logic        drop_zero_reg;
    logic [12:0] acc_reg, acc_next;
    logic [3:0]  bits_held_reg, bits_held_next;
    logic [3:0]  bytes_skipped_reg, bytes_skipped_next;
    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic        m_user_reg;
    logic        m_last_reg;

    sextet_t     sx;
    logic [12:0] acc_shifted;
    logic [3:0]  bits_sum;
    logic [3:0]  sh;
    logic [7:0]  byte_val;
    logic        have;
    logic        accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        sx                 = sextet_of(s_tdata);
        acc_shifted        = {acc_reg[6:0], sx.value};
        bits_sum           = {1'b0, bits_held_reg[2:0]} + 4'd6;
        sh                 = bits_sum - 4'd8;
        byte_val           = 8'(acc_shifted >> sh);
        have               = 1'b0;
        acc_next           = acc_reg;
        bits_held_next     = bits_held_reg;
        bytes_skipped_next = bytes_skipped_reg;
        if (sx.valid) begin
            acc_next       = acc_shifted;
            bits_held_next = bits_sum;
            if (bits_sum >= 4'd8) begin
                bits_held_next = sh;
                acc_next       = acc_shifted & ((13'd1 << sh) - 13'd1);
                if (bytes_skipped_reg < skip_prefix_reg) begin
                    bytes_skipped_next = bytes_skipped_reg + 4'd1;
                end else if (!(drop_zero_reg && byte_val == 8'd0)) begin
                    have = 1'b1;
                end
            end
        end
        if (s_tlast) begin
            acc_next           = 13'd0;
            bits_held_next     = 4'd0;
            bytes_skipped_next = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_prefix_reg   <= SKIP_PREFIX_RESET;
            drop_zero_reg     <= DROP_ZERO_RESET;
            acc_reg           <= 13'd0;
            bits_held_reg     <= 4'd0;
            bytes_skipped_reg <= 4'd0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SKIP_PREFIX: skip_prefix_reg <= cfg_wdata[3:0];
                    REG_DROP_ZERO:   drop_zero_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (accept) begin
                acc_reg           <= acc_next;
                bits_held_reg     <= bits_held_next;
                bytes_skipped_reg <= bytes_skipped_next;
                m_valid_reg       <= have || s_tlast;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= have ? byte_val : 8'd0;
            m_user_reg <= have;
            m_last_reg <= s_tlast;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> bits_held_reg == 4'd0 && bytes_skipped_reg == 4'd0
                              && acc_reg == 13'd0)
        else $error("state not cleared after the last item");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata == 8'd0)
        else $error("result without a byte that does not end the string");

    a_held_even: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !bits_held_reg[0] && !bits_held_reg[3])
        else $error("pending bit count out of range");
`endif

endmodule

`default_nettype wire
